[design/bpr_pkg.sv]
// Package for block part reassembly: sizes, codes, channel and control types.
// Used by bpr_ctrl, bpr_datapath and block_part_reassembly.
`default_nettype none
package bpr_pkg;
   localparam int PART_BYTES       = 64;
   localparam int MAX_PARTS        = 64;
   localparam int BUFFER_BYTES     = 4096;
   localparam int FULL_BLOCK_BYTES = 4092;

   localparam int PART_W  = $clog2(PART_BYTES);        // byte offset within a part
   localparam int SCNT_W  = $clog2(PART_BYTES + 1);    // staged byte count
   localparam int ADDR_W  = $clog2(BUFFER_BYTES);      // store address
   localparam int CNT_W   = $clog2(BUFFER_BYTES + 1);  // walk counter
   localparam int START_W = 8 + PART_W;                // part index * PART_BYTES
   localparam int MAP_W   = 64;
   localparam int NEED_W  = 7;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_HDR   = 2'd1,
      KIND_DATA  = 2'd2,
      KIND_FIN   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_STARTED    = 3'd0,
      ST_TAKEN      = 3'd1,
      ST_ACCEPTED   = 3'd2,
      ST_REJECTED   = 3'd3,
      ST_INCOMPLETE = 3'd4,
      ST_VALID      = 3'd5,
      ST_INVALID    = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  block_id;
      logic [11:0] block_size;
      logic [7:0]  part_index;
      logic [7:0]  check_byte;
      logic [7:0]  data_byte;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [MAP_W-1:0] pending_map;
      logic [6:0]       parts_expected;
      logic             partial_request;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       take;       // apply accepted request
      logic       cnt_inc;
      logic       stage_rd;
      logic       store_wr;   // copy write at start+cnt
      logic       store_rd;   // store read at cnt
      logic       hdr_load;
      logic       end_load;
      logic       sum_add;
      logic       commit;     // clear wanted bit
      logic       fin_fail;   // re-mark needed parts
      logic       st_wr;
      status_type st_val;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic commit_ok;
      logic incomplete;
      logic copy_last;
      logic hdr_last;
      logic sum_end;
      logic sum_ok;
   } sts_type;
endpackage
`default_nettype wire

[design/block_part_reassembly.sv]
// Block part reassembly top level: controller plus datapath.
// Depends on bpr_pkg, bpr_ctrl, bpr_datapath.
//
// Use:
//  - req channel (req_valid/req_stall/req_data) carries one request per item:
//    start block, part header, part data byte, or finish round.
//  - rsp channel (rsp_valid/rsp_stall/rsp_data) returns exactly one result
//    per request: status, pending part map, parts expected, partial flag.
//  - One request is in flight at a time; req_stall is high from acceptance
//    until its result has been taken.
// Sequencing (accept to rsp_valid):
//  - start, header, data byte, rejected part, incomplete finish: straight
//    from the accepting state to the response state.
//  - accepted part (last byte): copies len bytes from the stage into the
//    store, len up to 64, with one stage read and one store write each.
//  - complete finish: the single store read port walks the 4 header bytes
//    and then the payload one byte at a time before the sum is compared.
// Reset clears the part map, part and stage counts and part header; memories are not cleared.
// A stalled result holds its payload; the block waits in its response state.
`default_nettype none
module block_part_reassembly (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bpr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bpr_pkg::rsp_type      rsp_data
);
   import bpr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_last  (req_data.last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bpr_datapath u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_data),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp_data)
   );
endmodule
`default_nettype wire

[design/bpr_datapath.sv]
// Datapath: block state, part stage memory, block store memory, walk counter.
// Depends on bpr_pkg; driven by bpr_ctrl.
`default_nettype none
module bpr_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bpr_pkg::req_type req,
   input  wire bpr_pkg::cmd_type cmd,
   output bpr_pkg::sts_type      sts,
   output bpr_pkg::rsp_type      rsp
);
   import bpr_pkg::*;

   logic [7:0]        cur_ff, cur_in;
   logic [MAP_W-1:0]  wanted_ff, wanted_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic              ask_ff, ask_in;
   logic [7:0]        hblk_ff, hblk_in, hidx_ff, hidx_in, hchk_ff, hchk_in;
   logic [SCNT_W-1:0] scnt_ff, scnt_in, fill_ff, fill_in;
   logic [7:0]        ssum_ff, ssum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, end_ff, end_in;
   logic [31:0]       hbuf_ff, hbuf_in;
   logic [15:0]       acc_ff, acc_in;
   status_type        st_ff, st_in;
   logic [7:0]        sq_ff, rq_ff;

   logic [7:0]        stage_mem [PART_BYTES];
   logic [7:0]        store_mem [BUFFER_BYTES];

   logic [MAP_W-1:0]  need_mask, start_mask;
   logic [CNT_W-1:0]  n_raw, n_sat, len, start_c;
   logic [START_W-1:0] start;
   logic              room;
   logic [7:0]        sum_new, seed;
   logic [SCNT_W-1:0] scnt_new;
   logic [15:0]       hsize;
   logic [CNT_W-1:0]  hsize_sat;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   // part count for a start request
   always_comb begin
      n_raw = ((CNT_W'(req.block_size) + CNT_W'(4)) >> PART_W)
              + CNT_W'(req.block_size[PART_W-1:0] != '0);
      if (req.block_size == 12'(FULL_BLOCK_BYTES))
         n_sat = CNT_W'(MAX_PARTS);
      else if (n_raw > CNT_W'(MAX_PARTS))
         n_sat = CNT_W'(MAX_PARTS);
      else
         n_sat = n_raw;
      for (int i = 0; i < MAP_W; i++) begin
         start_mask[i] = CNT_W'(i) < n_sat;
         need_mask[i]  = NEED_W'(i) < need_ff;
      end
   end

   assign room     = scnt_ff < SCNT_W'(PART_BYTES);
   assign sum_new  = room ? ssum_ff + req.data_byte : ssum_ff;
   assign scnt_new = room ? scnt_ff + SCNT_W'(1) : scnt_ff;
   assign seed     = hblk_ff + hidx_ff;
   assign start    = START_W'(hidx_ff) << PART_W;
   assign start_c  = CNT_W'(start);

   assign sts.commit_ok = (hblk_ff == cur_ff)
                       && (start < START_W'(BUFFER_BYTES - 1))
                       && (hidx_ff < 8'(MAX_PARTS))
                       && (sum_new == hchk_ff);
   assign sts.incomplete = |(wanted_ff & need_mask);

   always_comb begin
      if (CNT_W'(BUFFER_BYTES) - start_c < CNT_W'(PART_BYTES))
         len = CNT_W'(BUFFER_BYTES) - start_c;
      else
         len = CNT_W'(PART_BYTES);
   end
   assign sts.copy_last = cnt_ff == len - CNT_W'(1);
   assign sts.hdr_last  = cnt_ff == CNT_W'(3);
   assign sts.sum_end   = cnt_ff == end_ff;
   assign sts.sum_ok    = acc_ff == hbuf_ff[31:16];

   assign hsize     = hbuf_ff[15:0];
   assign hsize_sat = (hsize > 16'(BUFFER_BYTES - 4)) ? CNT_W'(BUFFER_BYTES - 4)
                                                      : CNT_W'(hsize);

   always_comb begin
      cur_in    = cur_ff;
      wanted_in = wanted_ff;
      need_in   = need_ff;
      ask_in    = ask_ff;
      hblk_in   = hblk_ff;
      hidx_in   = hidx_ff;
      hchk_in   = hchk_ff;
      scnt_in   = scnt_ff;
      fill_in   = fill_ff;
      ssum_in   = ssum_ff;
      cnt_in    = cmd.cnt_inc ? cnt_ff + CNT_W'(1) : cnt_ff;
      end_in    = cmd.end_load ? hsize_sat + CNT_W'(4) : end_ff;
      hbuf_in   = cmd.hdr_load ? {rq_ff, hbuf_ff[31:8]} : hbuf_ff;
      acc_in    = cmd.end_load ? 16'd0 : (cmd.sum_add ? acc_ff + 16'(rq_ff) : acc_ff);
      st_in     = cmd.st_wr ? cmd.st_val : st_ff;
      if (cmd.commit)
         wanted_in[hidx_ff[5:0]] = 1'b0;
      if (cmd.fin_fail) begin
         wanted_in = wanted_ff | need_mask;
         ask_in    = 1'b0;
      end
      if (cmd.take) begin
         cnt_in = '0;
         case (kind_type'(req.kind))
            KIND_START: begin
               cur_in    = req.block_id;
               need_in   = NEED_W'(n_sat);
               wanted_in = start_mask;
               ask_in    = 1'b0;
               scnt_in   = '0;
               ssum_in   = seed;
               st_in     = ST_STARTED;
            end
            KIND_HDR: begin
               hblk_in = req.block_id;
               hidx_in = req.part_index;
               hchk_in = req.check_byte;
               scnt_in = '0;
               ssum_in = req.block_id + req.part_index;
               st_in   = ST_TAKEN;
            end
            KIND_DATA: begin
               if (req.last) begin
                  fill_in = scnt_new;
                  scnt_in = '0;
                  ssum_in = seed;
                  st_in   = ST_REJECTED;
               end else begin
                  scnt_in = scnt_new;
                  ssum_in = sum_new;
                  st_in   = ST_TAKEN;
               end
            end
            default: begin
               if (sts.incomplete) begin
                  ask_in = 1'b1;
                  st_in  = ST_INCOMPLETE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         wanted_ff <= '0;
         need_ff   <= '0;
         ask_ff    <= 1'b0;
         hblk_ff   <= '0;
         hidx_ff   <= '0;
         hchk_ff   <= '0;
         scnt_ff   <= '0;
         ssum_ff   <= '0;
         st_ff     <= ST_STARTED;
      end else begin
         cur_ff    <= cur_in;
         wanted_ff <= wanted_in;
         need_ff   <= need_in;
         ask_ff    <= ask_in;
         hblk_ff   <= hblk_in;
         hidx_ff   <= hidx_in;
         hchk_ff   <= hchk_in;
         scnt_ff   <= scnt_in;
         ssum_ff   <= ssum_in;
         st_ff     <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff <= fill_in;
      cnt_ff  <= cnt_in;
      end_ff  <= end_in;
      hbuf_ff <= hbuf_in;
      acc_ff  <= acc_in;
   end

   // part stage
   always_ff @(posedge clock) begin
      if (cmd.take && (kind_type'(req.kind) == KIND_DATA) && room)
         stage_mem[scnt_ff[PART_W-1:0]] <= req.data_byte;
      if (cmd.stage_rd)
         sq_ff <= stage_mem[cnt_ff[PART_W-1:0]];
   end

   // block store; unfilled stage positions copy as zero
   assign wr_addr = ADDR_W'(start_c + cnt_ff);
   assign wr_data = (cnt_ff < CNT_W'(fill_ff)) ? sq_ff : 8'h00;

   always_ff @(posedge clock) begin
      if (cmd.store_wr)
         store_mem[wr_addr] <= wr_data;
      if (cmd.store_rd)
         rq_ff <= store_mem[cnt_ff[ADDR_W-1:0]];
   end

   assign rsp.status          = st_ff;
   assign rsp.pending_map     = wanted_ff;
   assign rsp.parts_expected  = need_ff;
   assign rsp.partial_request = ask_ff;
endmodule
`default_nettype wire

[design/bpr_ctrl.sv]
// Controller FSM: request/response handshake, part copy and validation walks.
// Depends on bpr_pkg; drives bpr_datapath.
`default_nettype none
module bpr_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_kind,
   input  wire logic             req_last,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire bpr_pkg::sts_type sts,
   output bpr_pkg::cmd_type      cmd
);
   import bpr_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_CRD  = 10'b0000000010,
      S_CWR  = 10'b0000000100,
      S_HRD  = 10'b0000001000,
      S_HAC  = 10'b0000010000,
      S_PREP = 10'b0000100000,
      S_SRD  = 10'b0001000000,
      S_SAC  = 10'b0010000000,
      S_CMP  = 10'b0100000000,
      S_RESP = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_RESP;
               if ((kind_type'(req_kind) == KIND_DATA) && req_last && sts.commit_ok)
                  state_in = S_CRD;
               if ((kind_type'(req_kind) == KIND_FIN) && !sts.incomplete)
                  state_in = S_HRD;
            end
         end
         S_CRD: begin
            cmd.stage_rd = 1'b1;
            state_in     = S_CWR;
         end
         S_CWR: begin
            cmd.store_wr = 1'b1;
            cmd.cnt_inc  = 1'b1;
            state_in     = S_CRD;
            if (sts.copy_last) begin
               cmd.commit = 1'b1;
               cmd.st_wr  = 1'b1;
               cmd.st_val = ST_ACCEPTED;
               state_in   = S_RESP;
            end
         end
         S_HRD: begin
            cmd.store_rd = 1'b1;
            state_in     = S_HAC;
         end
         S_HAC: begin
            cmd.hdr_load = 1'b1;
            cmd.cnt_inc  = 1'b1;
            state_in     = sts.hdr_last ? S_PREP : S_HRD;
         end
         S_PREP: begin
            cmd.end_load = 1'b1;
            state_in     = S_SRD;
         end
         S_SRD: begin
            if (sts.sum_end) begin
               state_in = S_CMP;
            end else begin
               cmd.store_rd = 1'b1;
               state_in     = S_SAC;
            end
         end
         S_SAC: begin
            cmd.sum_add = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in    = S_SRD;
         end
         S_CMP: begin
            cmd.st_wr    = 1'b1;
            cmd.st_val   = sts.sum_ok ? ST_VALID : ST_INVALID;
            cmd.fin_fail = !sts.sum_ok;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= S_IDLE;
      else
         state_ff <= state_in;
   end
endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for block_part_reassembly: directed table, then random block traffic.
// Depends on bpr_pkg and the block_part_reassembly RTL; checks each response against a
// cycle-free behavioral predictor, or against the typed result in the directed table.
`timescale 1ns / 100ps
module tb;
   import bpr_pkg::*;

   localparam int ITEM_TARGET = 1900;
   localparam int QUIET_AFTER = 1750;   // no idling past this many requests
   localparam int HOLD_AT     = 400;    // long response hold-off starts here
   localparam int HOLD_LEN    = 400;
   localparam int WATCHDOG    = 40000;  // cycles with no handshake at all
   localparam int REQ_W       = $bits(req_type);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   always #1 clock = ~clock;

   block_part_reassembly dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // ---------------------------------------------------------------------
   // Predictor state: a private copy of the reassembly bookkeeping
   // ---------------------------------------------------------------------
   logic [7:0]  cur_block = '0, hdr_block = '0, hdr_index = '0, hdr_check = '0;
   logic [7:0]  stage_sum = '0;
   logic [63:0] wanted = '0;
   logic [6:0]  need_cnt = '0;
   int          stage_cnt = 0;
   logic [7:0]  stage_buf [PART_BYTES];
   logic [7:0]  store_img [BUFFER_BYTES];
   bit          written   [BUFFER_BYTES];   // store bytes ever committed
   bit          ask_partial;

   rsp_type expected_rsp [$];
   int      sent = 0;
   int      errors = 0;
   bit      quiet = 1'b0;

   function automatic logic [63:0] low_mask(int n);
      if (n >= 64) return '1;
      return (64'd1 << n) - 64'd1;
   endfunction

   function automatic int parts_for(int size);
      int n;
      if (size == FULL_BLOCK_BYTES) return MAX_PARTS;
      n = (4 + size) / PART_BYTES;
      if (size % PART_BYTES != 0) n++;
      return (n > MAX_PARTS) ? MAX_PARTS : n;
   endfunction

   function automatic void empty_stage();
      stage_cnt = 0;
      stage_sum = hdr_block + hdr_index;
      foreach (stage_buf[i]) stage_buf[i] = 8'h00;
   endfunction

   // store[0..1] = payload size, store[2..3] = 16-bit payload sum
   function automatic int header_size();
      int sz;
      sz = {store_img[1], store_img[0]};
      return (sz > BUFFER_BYTES - 4) ? BUFFER_BYTES - 4 : sz;
   endfunction

   function automatic bit payload_ok();
      logic [15:0] acc;
      int          sz;
      acc = '0;
      sz  = header_size();
      for (int i = 0; i < sz; i++) acc += store_img[4 + i];
      return acc == {store_img[3], store_img[2]};
   endfunction

   function automatic bit part_commits();
      int start, len;
      start = int'(hdr_index) * PART_BYTES;
      if (hdr_block != cur_block) return 1'b0;
      if (start >= BUFFER_BYTES - 1) return 1'b0;
      if (hdr_index >= MAX_PARTS) return 1'b0;
      if (stage_sum != hdr_check) return 1'b0;
      len = (start + PART_BYTES > BUFFER_BYTES) ? BUFFER_BYTES - start : PART_BYTES;
      for (int i = 0; i < len; i++) begin
         store_img[start + i] = stage_buf[i];
         written[start + i]   = 1'b1;
      end
      wanted[hdr_index[5:0]] = 1'b0;
      return 1'b1;
   endfunction

   // Apply one accepted request, return the response it must produce.
   function automatic rsp_type reassembly_step(req_type r);
      rsp_type    o;
      status_type st;
      logic [63:0] need;
      int          n;
      st = ST_TAKEN;
      case (kind_type'(r.kind))
         KIND_START: begin
            n           = parts_for(int'(r.block_size));
            cur_block   = r.block_id;
            need_cnt    = n[6:0];
            wanted      = low_mask(n);
            ask_partial = 1'b0;
            empty_stage();
            st = ST_STARTED;
         end
         KIND_HDR: begin
            hdr_block = r.block_id;
            hdr_index = r.part_index;
            hdr_check = r.check_byte;
            empty_stage();
         end
         KIND_DATA: begin
            if (stage_cnt < PART_BYTES) begin
               stage_buf[stage_cnt] = r.data_byte;
               stage_cnt++;
               stage_sum += r.data_byte;
            end
            if (r.last) begin
               st = part_commits() ? ST_ACCEPTED : ST_REJECTED;
               empty_stage();
            end
         end
         default: begin
            need = low_mask(int'(need_cnt));
            if ((wanted & need) != '0) begin
               ask_partial = 1'b1;
               st = ST_INCOMPLETE;
            end else if (payload_ok()) begin
               st = ST_VALID;
            end else begin
               wanted |= need;
               ask_partial = 1'b0;
               st = ST_INVALID;
            end
         end
      endcase
      o.status          = st;
      o.pending_map     = wanted;
      o.parts_expected  = need_cnt;
      o.partial_request = ask_partial;
      return o;
   endfunction

   // A complete finish walks the store; only allow it over bytes already written.
   function automatic bit finish_safe();
      int sz;
      if ((wanted & low_mask(int'(need_cnt))) != '0) return 1'b1;
      for (int i = 0; i < 4; i++) if (!written[i]) return 1'b0;
      sz = header_size();
      for (int i = 0; i < sz; i++) if (!written[4 + i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic req_type mk(kind_type k, int id, int size, int idx, int chk,
                                  int dat, int lst);
      req_type r;
      r.kind = k;                r.block_id = 8'(id);    r.block_size = 12'(size);
      r.part_index = 8'(idx);    r.check_byte = 8'(chk); r.data_byte = 8'(dat);
      r.last = 1'(lst);
      return r;
   endfunction

   function automatic rsp_type rs(status_type st, logic [63:0] m, logic [6:0] n, logic p);
      rsp_type o;
      o.status = st; o.pending_map = m; o.parts_expected = n; o.partial_request = p;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: hold valid until accepted, then predict
   // ---------------------------------------------------------------------
   task automatic send(req_type r, bit typed = 1'b0, rsp_type typed_rsp = '0);
      rsp_type pred;
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pred = reassembly_step(r);
      expected_rsp.push_back(typed ? typed_rsp : pred);
      sent++;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic send_finish();
      if (finish_safe())
         send(mk(KIND_FIN, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
   endtask

   task automatic noise();
      req_type r;
      r = req_type'(REQ_W'({$urandom, $urandom}));
      if (kind_type'(r.kind) == KIND_FIN) send_finish();
      else send(r);
   endtask

   // One part: header, then a run of data bytes with last on the final one.
   task automatic send_part(logic [7:0] id, int idx, ref logic [7:0] img [BUFFER_BYTES]);
      logic [7:0] chk;
      int         len, roll;
      roll = $urandom_range(0, 19);
      len  = (roll < 15) ? PART_BYTES :
             (roll < 18) ? $urandom_range(1, PART_BYTES - 1) : $urandom_range(65, 70);
      chk = id + idx[7:0];
      for (int i = 0; i < len && i < PART_BYTES; i++) chk += img[idx * PART_BYTES + i];
      if ($urandom_range(0, 11) == 0) chk ^= 8'(1 << $urandom_range(0, 7));
      send(mk(KIND_HDR, id, $urandom, idx, chk, $urandom, $urandom));
      for (int i = 0; i < len; i++)
         send(mk(KIND_DATA, $urandom, $urandom, $urandom, $urandom,
                 (i < PART_BYTES) ? img[idx * PART_BYTES + i] : 8'($urandom),
                 i == len - 1));
   endtask

   // A whole block transfer with retry rounds, the way a receiver runs it.
   task automatic run_block();
      logic [7:0]  img [BUFFER_BYTES];
      logic [7:0]  id;
      logic [11:0] size;
      logic [15:0] acc;
      int          n, sz, roll;
      id   = 8'($urandom);
      roll = $urandom_range(0, 39);
      size = (roll == 0) ? 12'(FULL_BLOCK_BYTES) :
             (roll == 1) ? 12'($urandom_range(3500, 4095)) : 12'($urandom_range(0, 400));
      n = parts_for(int'(size));
      foreach (img[i]) img[i] = 8'($urandom);
      img[0] = size[7:0];
      img[1] = {4'h0, size[11:8]};
      sz  = (size > BUFFER_BYTES - 4) ? BUFFER_BYTES - 4 : int'(size);
      acc = '0;
      for (int i = 0; i < sz; i++) acc += img[4 + i];
      img[2] = acc[7:0];
      img[3] = acc[15:8];
      if (sz > 0 && $urandom_range(0, 5) == 0) img[4 + $urandom_range(0, sz - 1)] ^= 8'h5A;
      send(mk(KIND_START, id, size, $urandom, $urandom, $urandom, $urandom));
      for (int round = 0; round < 3; round++) begin
         for (int p = 0; p < n; p++) begin
            if (sent >= ITEM_TARGET) break;
            if (!wanted[p] || cur_block != id) continue;
            if (round == 0 && $urandom_range(0, 3) == 0) continue;
            if ($urandom_range(0, 29) == 0) noise();
            send_part(id, p, img);
         end
         send_finish();
         if ((wanted & low_mask(int'(need_cnt))) == '0 || sent >= ITEM_TARGET) break;
      end
   endtask

   initial begin
      rsp_type full;
      full = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table: start extremes, checksum/id/index rejects, valid and invalid finish
      begin
         req_type r [$];
         bit      t [$];
         rsp_type e [$];
         r.push_back(mk(KIND_START, 8'h05, 12'd4092, 0, 0, 0, 0)); t.push_back(1);
         e.push_back(rs(ST_STARTED, '1, 7'd64, 1'b0));
         r.push_back(mk(KIND_FIN, 0, 0, 0, 0, 0, 0)); t.push_back(1);
         e.push_back(rs(ST_INCOMPLETE, '1, 7'd64, 1'b1));
         r.push_back(mk(KIND_START, 8'h05, 12'd4091, 0, 0, 0, 0)); t.push_back(1);
         e.push_back(rs(ST_STARTED, '1, 7'd64, 1'b0));
         r.push_back(mk(KIND_START, 8'h07, 12'd60, 0, 0, 0, 0)); t.push_back(1);
         e.push_back(rs(ST_STARTED, 64'h3, 7'd2, 1'b0));
         r.push_back(mk(KIND_START, 8'h00, 12'd0, 0, 0, 0, 0)); t.push_back(1);
         e.push_back(rs(ST_STARTED, 64'h0, 7'd0, 1'b0));
         r.push_back(mk(KIND_START, 8'hFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 1)); t.push_back(1);
         e.push_back(rs(ST_STARTED, '1, 7'd64, 1'b0));
         r.push_back(mk(KIND_START, 8'h3C, 12'd1, 0, 0, 0, 0)); t.push_back(1);
         e.push_back(rs(ST_STARTED, 64'h1, 7'd1, 1'b0));
         // good part 0: size 1, sum 0x00AB, payload 0xAB
         r.push_back(mk(KIND_HDR, 8'h3C, 0, 8'h00, 8'h93, 0, 0)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_DATA, 0, 0, 0, 0, 8'h01, 0)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_DATA, 0, 0, 0, 0, 8'h00, 0)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_DATA, 0, 0, 0, 0, 8'hAB, 0)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_DATA, 0, 0, 0, 0, 8'h00, 0)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_DATA, 0, 0, 0, 0, 8'hAB, 1)); t.push_back(1);
         e.push_back(rs(ST_ACCEPTED, 64'h0, 7'd1, 1'b0));
         r.push_back(mk(KIND_FIN, 0, 0, 0, 0, 0, 0)); t.push_back(1);
         e.push_back(rs(ST_VALID, 64'h0, 7'd1, 1'b0));
         // wrong block id
         r.push_back(mk(KIND_HDR, 8'h3D, 0, 8'h00, 8'h00, 0, 0)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_DATA, 0, 0, 0, 0, 8'hFF, 1)); t.push_back(1);
         e.push_back(rs(ST_REJECTED, 64'h0, 7'd1, 1'b0));
         // index far out of range
         r.push_back(mk(KIND_HDR, 8'h3C, 0, 8'hFF, 8'hFF, 0, 0)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_DATA, 0, 0, 0, 0, 8'h00, 1)); t.push_back(1);
         e.push_back(rs(ST_REJECTED, 64'h0, 7'd1, 1'b0));
         // last part of the buffer, then a byte with no new header
         r.push_back(mk(KIND_HDR, 8'h3C, 0, 8'd63, 8'h7B, 0, 0)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_DATA, 0, 0, 0, 0, 8'h00, 1)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_DATA, 0, 0, 0, 0, 8'h00, 1)); t.push_back(0); e.push_back(full);
         // part 0 with a payload that breaks the header sum
         r.push_back(mk(KIND_HDR, 8'h3C, 0, 8'h00, 8'hE8, 0, 0)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_DATA, 0, 0, 0, 0, 8'h01, 0)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_DATA, 0, 0, 0, 0, 8'h00, 0)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_DATA, 0, 0, 0, 0, 8'h00, 0)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_DATA, 0, 0, 0, 0, 8'h00, 0)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_DATA, 0, 0, 0, 0, 8'hAB, 1)); t.push_back(0); e.push_back(full);
         r.push_back(mk(KIND_FIN, 0, 0, 0, 0, 0, 0)); t.push_back(1);
         e.push_back(rs(ST_INVALID, 64'h1, 7'd1, 1'b0));
         r.push_back(mk(KIND_FIN, 0, 0, 0, 0, 0, 0)); t.push_back(1);
         e.push_back(rs(ST_INCOMPLETE, 64'h1, 7'd1, 1'b1));
         foreach (r[i]) send(r[i], t[i], e[i]);
      end

      while (sent < ITEM_TARGET) begin
         if (sent > QUIET_AFTER) quiet = 1'b1;
         if ($urandom_range(0, 9) == 0) noise();
         else run_block();
      end
      req_valid <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0)
         $display("[block_part_reassembly] OK");
      else
         $display("[block_part_reassembly] ERROR");
      $finish;
   end

   // Response side: random stall bursts, plus one long hold-off to back up the input.
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sent > HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_LEN) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Response checker and watchdog
   int idle_cycles = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("[block_part_reassembly] ERROR");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.pending_map !== want.pending_map ||
                   rsp_data.parts_expected !== want.parts_expected ||
                   rsp_data.partial_request !== want.partial_request) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch: expected st=%0d map=%h n=%0d p=%0b,",
                               " got st=%0d map=%h n=%0d p=%0b"},
                              want.status, want.pending_map, want.parts_expected,
                              want.partial_request, rsp_data.status, rsp_data.pending_map,
                              rsp_data.parts_expected, rsp_data.partial_request);
               end
            end
         end
      end
   end
endmodule
